FILE: src/crc_bit_serial_gen_check_top_defines.svh
// Assertion macros shared by the CRC bit-serial generator/checker RTL.
// Each use samples on clk and is disabled while rst_n is low.
`ifndef CRC_BIT_SERIAL_GEN_CHECK_TOP_DEFINES_SVH
`define CRC_BIT_SERIAL_GEN_CHECK_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CRCBS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crcbs assertion failed");
`define CRCBS_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("crcbs forbidden condition");
`else
`define CRCBS_ASSERT(lbl, prop)
`define CRCBS_NEVER(lbl, expr)
`endif
`endif

FILE: src/crcbs_pkg.sv
// Types and constants for the bit-serial CRC generator/checker.
// No dependencies; used by crcbs_cell, crcbs_chain and the top level.
package crcbs_pkg;

    localparam int DEG_W  = 6;
    localparam int POLY_W = 33;
    localparam int CFG_W  = 33;

    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_GEN   = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    localparam logic CFG_POLY   = 1'b0;
    localparam logic CFG_DEGREE = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic       data_bit;
    } in_item_t;

    typedef struct packed {
        logic out_bit;
        logic frame_ok;
        logic is_check;
        logic last;
    } out_item_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_DIV,
        CM_SHIFT,
        CM_CLEAR,
        CM_MASK
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       din;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_EMIT
    } state_t;

endpackage

FILE: src/crcbs_cell.sv
// One remainder bit of the CRC division chain.
// Depends on crcbs_pkg (cell_mode_t, chain_ctrl_t).
module crcbs_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crcbs_pkg::chain_ctrl_t ctrl,
    input  logic                 en,
    input  logic                 sin,
    input  logic                 fb,
    input  logic                 poly,
    output logic                 q
);

    logic q_reg;
    logic q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.mode)
            crcbs_pkg::CM_HOLD:  q_next = q_reg;
            crcbs_pkg::CM_DIV:   q_next = en & (sin ^ (fb & poly));
            crcbs_pkg::CM_SHIFT: q_next = en & sin;
            crcbs_pkg::CM_CLEAR: q_next = 1'b0;
            crcbs_pkg::CM_MASK:  q_next = en & q_reg;
            default:             q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/crcbs_chain.sv
// Row of remainder cells; selects the leading bit and flags an all-zero remainder.
// Depends on crcbs_pkg and crcbs_cell.
module crcbs_chain #(
    parameter int W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crcbs_pkg::chain_ctrl_t        ctrl,
    input  logic [W-1:0]                  poly,
    input  logic [crcbs_pkg::DEG_W-1:0]   deg,
    output logic                          top,
    output logic                          zero
);

    logic [W-1:0] r;
    logic [W-1:0] mask;
    logic [W-1:0] sel;
    logic [W-1:0] sin;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        assign mask[i] = (deg > crcbs_pkg::DEG_W'(i));
        assign sel[i]  = (deg == crcbs_pkg::DEG_W'(i + 1));
        if (i == 0)
        begin : g_first
            assign sin[i] = ctrl.din;
        end
        else
        begin : g_rest
            assign sin[i] = r[i-1];
        end

        crcbs_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (ctrl),
            .en   (mask[i]),
            .sin  (sin[i]),
            .fb   (top),
            .poly (poly[i]),
            .q    (r[i])
        );
    end

    assign top  = |(r & sel);
    assign zero = ~|(r & mask);

endmodule

FILE: src/crc_bit_serial_gen_check_top.sv
// Top level of the bit-serial CRC generator/checker: control, config and output register.
// Depends on crcbs_pkg, crcbs_chain, crcbs_cell and the assertion header.
//
// Usage:
//   in channel  : in_valid/in_ready carry in_item (action, data_bit).
//   out channel : out_valid/out_ready carry out_item (out_bit, frame_ok, is_check, last).
//   config port : cfg_we writes cfg_wdata into register cfg_addr (0 poly, 1 degree).
// A data item updates the remainder in the cycle it is accepted and its pass-through
// bit appears on out in the next cycle; data items are taken one per cycle while the
// output register is free. A check item gives its verdict in the next cycle and clears
// the remainder. A generate item shifts d zero bits through the chain (d = effective
// degree), then emits d remainder bits MSB first, one per cycle the receiver
// takes; the next item is accepted after the last CRC bit is loaded.
// The single output register is refilled in the cycle it is taken, so a stalled
// receiver stops input acceptance and emission without losing or repeating items.
// Reset clears the remainder, empties the output register and restores the default
// generator 10110 with degree 4.
`include "crc_bit_serial_gen_check_top_defines.svh"
module crc_bit_serial_gen_check_top #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  crcbs_pkg::in_item_t               in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output crcbs_pkg::out_item_t              out_item,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [crcbs_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int W = (MAX_DEGREE < 32) ? MAX_DEGREE : 32;

    logic [crcbs_pkg::POLY_W-1:0] gen_poly_reg;
    logic [crcbs_pkg::DEG_W-1:0]  gen_degree_reg;
    logic [crcbs_pkg::DEG_W-1:0]  deg_eff;
    logic [crcbs_pkg::DEG_W-1:0]  deg_last;

    crcbs_pkg::state_t            state_reg;
    crcbs_pkg::state_t            state_next;
    logic [crcbs_pkg::DEG_W-1:0]  cnt_reg;
    logic [crcbs_pkg::DEG_W-1:0]  cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    crcbs_pkg::out_item_t         out_item_reg;
    crcbs_pkg::out_item_t         out_item_next;

    crcbs_pkg::chain_ctrl_t       ctrl;
    logic                         chain_top;
    logic                         chain_zero;
    logic                         out_free;
    logic                         in_fire;
    logic                         load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_poly_reg   <= crcbs_pkg::POLY_W'(22);
            gen_degree_reg <= crcbs_pkg::DEG_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                crcbs_pkg::CFG_POLY:   gen_poly_reg   <= cfg_wdata;
                crcbs_pkg::CFG_DEGREE: gen_degree_reg <= cfg_wdata[crcbs_pkg::DEG_W-1:0];
                default:               gen_poly_reg   <= gen_poly_reg;
            endcase
        end
    end

    always_comb
    begin
        if (gen_degree_reg == '0)
        begin
            deg_eff = crcbs_pkg::DEG_W'(1);
        end
        else if (gen_degree_reg > crcbs_pkg::DEG_W'(W))
        begin
            deg_eff = crcbs_pkg::DEG_W'(W);
        end
        else
        begin
            deg_eff = gen_degree_reg;
        end
    end

    assign deg_last = deg_eff - crcbs_pkg::DEG_W'(1);

    crcbs_chain #(
        .W(W)
    ) u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .poly (gen_poly_reg[W-1:0]),
        .deg  (deg_eff),
        .top  (chain_top),
        .zero (chain_zero)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl.mode     = crcbs_pkg::CM_HOLD;
        ctrl.din      = 1'b0;
        in_ready      = 1'b0;
        load          = 1'b0;
        out_item_next = out_item_reg;
        unique case (state_reg)
            crcbs_pkg::ST_RUN:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    unique case (in_item.action)
                        crcbs_pkg::ACT_DATA:
                        begin
                            ctrl.mode     = crcbs_pkg::CM_DIV;
                            ctrl.din      = in_item.data_bit;
                            load          = 1'b1;
                            out_item_next = '{out_bit: in_item.data_bit, frame_ok: 1'b0,
                                              is_check: 1'b0, last: 1'b1};
                        end
                        crcbs_pkg::ACT_GEN:
                        begin
                            ctrl.mode = crcbs_pkg::CM_DIV;
                            if (deg_eff == crcbs_pkg::DEG_W'(1))
                            begin
                                state_next = crcbs_pkg::ST_EMIT;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                state_next = crcbs_pkg::ST_FLUSH;
                                cnt_next   = crcbs_pkg::DEG_W'(1);
                            end
                        end
                        crcbs_pkg::ACT_CHECK:
                        begin
                            ctrl.mode     = crcbs_pkg::CM_CLEAR;
                            load          = 1'b1;
                            out_item_next = '{out_bit: 1'b0, frame_ok: chain_zero,
                                              is_check: 1'b1, last: 1'b1};
                        end
                        default:
                        begin
                            // unused action: no result, remainder trimmed to the degree
                            ctrl.mode = crcbs_pkg::CM_MASK;
                        end
                    endcase
                end
            end
            crcbs_pkg::ST_FLUSH:
            begin
                ctrl.mode = crcbs_pkg::CM_DIV;
                if (cnt_reg == deg_last)
                begin
                    state_next = crcbs_pkg::ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + crcbs_pkg::DEG_W'(1);
                end
            end
            crcbs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.mode     = crcbs_pkg::CM_SHIFT;
                    load          = 1'b1;
                    out_item_next = '{out_bit: chain_top, frame_ok: 1'b0,
                                      is_check: 1'b0, last: (cnt_reg == deg_last)};
                    if (cnt_reg == deg_last)
                    begin
                        state_next = crcbs_pkg::ST_RUN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + crcbs_pkg::DEG_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = crcbs_pkg::ST_RUN;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crcbs_pkg::ST_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `CRCBS_ASSERT(a_data_result, (in_fire && in_item.action == crcbs_pkg::ACT_DATA) |=> (out_valid && out_item.last && !out_item.is_check))
    `CRCBS_ASSERT(a_check_clears, (in_fire && in_item.action == crcbs_pkg::ACT_CHECK) |=> chain_zero)
    `CRCBS_ASSERT(a_gen_flush, (in_fire && in_item.action == crcbs_pkg::ACT_GEN && deg_eff != crcbs_pkg::DEG_W'(1)) |=> (state_reg == crcbs_pkg::ST_FLUSH))
    `CRCBS_ASSERT(a_emit_done, (state_reg == crcbs_pkg::ST_EMIT && out_free && cnt_reg == deg_last) |=> (state_reg == crcbs_pkg::ST_RUN && out_valid && out_item.last))
    `CRCBS_NEVER(n_ready_busy, in_ready && state_reg != crcbs_pkg::ST_RUN)

endmodule
